### src/rtmml_pkg.sv
// ----------------------------------------------------------------------------
// Route table lookup package
// Shared types, codes and defaults for the route table and its cells.
// ----------------------------------------------------------------------------
`default_nettype none

package rtmml_pkg;

  // Default table depth.
  localparam int unsigned MaxEntriesDef = 128;

  // Field widths.
  localparam int unsigned AddrW   = 32;
  localparam int unsigned IfaceW  = 4;
  localparam int unsigned CostW   = 30;
  localparam int unsigned CmdW    = 2;
  localparam int unsigned StatusW = 2;
  localparam int unsigned CountW  = 8;

  // Command codes.
  localparam logic [CmdW-1:0] CmdAdd    = 2'd0;
  localparam logic [CmdW-1:0] CmdRemove = 2'd1;
  localparam logic [CmdW-1:0] CmdLookup = 2'd2;
  localparam logic [CmdW-1:0] CmdClear  = 2'd3;

  // Status codes.
  localparam logic [StatusW-1:0] StOk      = 2'd0;
  localparam logic [StatusW-1:0] StFull    = 2'd1;
  localparam logic [StatusW-1:0] StMissing = 2'd2;

  // One stored route.
  typedef struct packed {
    logic [AddrW-1:0]  dest;
    logic [AddrW-1:0]  gateway;
    logic [IfaceW-1:0] iface;
    logic              kind;
    logic [CostW-1:0]  cost;
  } entry_t;

  // Search state handed from cell to cell.
  typedef struct packed {
    logic              found;    // a destination match at or before this cell
    logic              hit;      // a full lookup match at or before this cell
    logic [CostW-1:0]  cost;     // best metric so far
    logic [AddrW-1:0]  gateway;  // gateway of the best match so far
  } carry_t;

  // Control sent from the sequencer to every cell.
  typedef struct packed {
    logic             wr_en;
    logic             shift_en;
    logic [AddrW-1:0] key_dest;
    logic [IfaceW-1:0] key_iface;
  } cell_ctrl_t;

endpackage

`default_nettype wire

### src/route_table_min_metric_lookup.sv
// ----------------------------------------------------------------------------
// Route table with minimum-metric lookup
// A packed table of routes held in a row of cells, one route per cell.
// ----------------------------------------------------------------------------
// Add and clear do not enter the search: busy stays low and the result
// strobes in the following cycle. Remove and lookup walk the row of cells:
// the search result ripples through it one cell per clock, then the done
// state settles the result and, for remove, shifts the later routes down in
// a single step. Each transaction gives one result, shown for one cycle under
// result_valid_o; the receiver cannot stall it, so it must take every
// result as it appears.
`default_nettype none

module route_table_min_metric_lookup
  import rtmml_pkg::*;
#(
  parameter int unsigned MaxEntries = MaxEntriesDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [CmdW-1:0]    cmd_i,
  input  wire logic [AddrW-1:0]   dest_addr_i,
  input  wire logic [AddrW-1:0]   gateway_addr_i,
  input  wire logic [IfaceW-1:0]  iface_id_i,
  input  wire logic               route_kind_i,
  input  wire logic [CostW-1:0]   route_metric_i,
  output logic                    result_valid_o,
  output logic [StatusW-1:0]      status_o,
  output logic [AddrW-1:0]        found_gateway_o,
  output logic [CountW-1:0]       entry_count_o
);

  localparam int unsigned CntW  = $clog2(MaxEntries + 1);
  localparam int unsigned WalkW = $clog2(MaxEntries);
  localparam logic [CntW-1:0]  CntMax  = CntW'(MaxEntries);
  localparam logic [WalkW-1:0] WalkEnd = WalkW'(MaxEntries - 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_WALK = 3'b010,
    S_DONE = 3'b100
  } state_e;

  state_e            state_q, state_d;
  logic [CntW-1:0]   count_q, count_d;
  logic [WalkW-1:0]  walk_q, walk_d;
  logic [CmdW-1:0]   op_q, op_d;
  logic [AddrW-1:0]  key_dest_q, key_dest_d;
  logic [IfaceW-1:0] key_iface_q, key_iface_d;
  logic              strobe_q, strobe_d;
  logic [StatusW-1:0] status_q, status_d;
  logic [AddrW-1:0]  gw_q, gw_d;
  logic              accept;
  cell_ctrl_t        ctrl;
  entry_t            add_entry;
  entry_t            entries [MaxEntries];
  carry_t            carries [MaxEntries];
  carry_t            tail;

  assign busy   = (state_q != S_IDLE);
  assign accept = start && !busy;
  assign tail   = carries[MaxEntries-1];

  assign add_entry = '{dest: dest_addr_i, gateway: gateway_addr_i, iface: iface_id_i,
                       kind: route_kind_i, cost: route_metric_i};

  // Sequencer for the commands.
  always_comb begin
    state_d       = state_q;
    count_d       = count_q;
    walk_d        = walk_q;
    op_d          = op_q;
    key_dest_d    = key_dest_q;
    key_iface_d   = key_iface_q;
    strobe_d      = 1'b0;
    status_d      = status_q;
    gw_d          = gw_q;
    ctrl.wr_en    = 1'b0;
    ctrl.shift_en = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          op_d        = cmd_i;
          key_dest_d  = dest_addr_i;
          key_iface_d = iface_id_i;
          walk_d      = '0;
          unique case (cmd_i) inside
            CmdAdd: begin
              strobe_d = 1'b1;
              gw_d     = '0;
              if (count_q >= CntMax) begin
                status_d = StFull;
              end else begin
                status_d   = StOk;
                ctrl.wr_en = 1'b1;
                count_d    = count_q + 1'b1;
              end
            end
            CmdClear: begin
              strobe_d = 1'b1;
              gw_d     = '0;
              status_d = StOk;
              count_d  = '0;
            end
            CmdRemove, CmdLookup: begin
              state_d = S_WALK;
            end
          endcase
        end
      end
      S_WALK: begin
        walk_d = walk_q + 1'b1;
        if (walk_q == WalkEnd) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        strobe_d = 1'b1;
        state_d  = S_IDLE;
        if (op_q == CmdRemove) begin
          gw_d = '0;
          if (tail.found) begin
            status_d      = StOk;
            ctrl.shift_en = 1'b1;
            count_d       = count_q - 1'b1;
          end else begin
            status_d = StMissing;
          end
        end else begin
          status_d = tail.hit ? StOk : StMissing;
          gw_d     = tail.hit ? tail.gateway : '0;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    ctrl.key_dest  = key_dest_q;
    ctrl.key_iface = key_iface_q;
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      count_q  <= '0;
      walk_q   <= '0;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      walk_q   <= walk_d;
      strobe_q <= strobe_d;
    end
  end

  // Key and result registers.
  always_ff @(posedge clk_i) begin
    op_q        <= op_d;
    key_dest_q  <= key_dest_d;
    key_iface_q <= key_iface_d;
    status_q    <= status_d;
    gw_q        <= gw_d;
  end

  // Row of cells, one route each.
  for (genvar i = 0; i < MaxEntries; i++) begin : g_cell
    localparam logic [CntW-1:0] Idx = CntW'(i);
    carry_t carry_in;
    entry_t next_in;
    if (i == 0) begin : g_head
      assign carry_in = '0;
    end else begin : g_body
      assign carry_in = carries[i-1];
    end
    if (i == MaxEntries - 1) begin : g_last
      assign next_in = entries[i];
    end else begin : g_mid
      assign next_in = entries[i+1];
    end
    rtmml_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .sel_i   (count_q == Idx),
      .valid_i (Idx < count_q),
      .add_i   (add_entry),
      .next_i  (next_in),
      .carry_i (carry_in),
      .entry_o (entries[i]),
      .carry_o (carries[i])
    );
  end

  assign result_valid_o  = strobe_q;
  assign status_o        = status_q;
  assign found_gateway_o = gw_q;
  assign entry_count_o   = CountW'(count_q);

  // The entry count never passes the table depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= CntMax)
    else $error("entry count above table depth");

  // An accepted add or clear gives its result in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (cmd_i == CmdAdd || cmd_i == CmdClear) |=> result_valid_o)
    else $error("add or clear result missing");

  // The final search cycle always delivers a result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DONE |=> result_valid_o && !busy)
    else $error("search result missing");

  // No result appears while the search is rippling through the cells.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_WALK |-> !result_valid_o)
    else $error("result during search");

  // A successful remove lowers the count by one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DONE && op_q == CmdRemove && tail.found |=>
      count_q == $past(count_q) - 1'b1)
    else $error("remove count mismatch");

endmodule

`default_nettype wire

### src/rtmml_cell.sv
// ----------------------------------------------------------------------------
// Route table cell
// Holds one route, compares it with the search key and passes the running
// search result on to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module rtmml_cell
  import rtmml_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire cell_ctrl_t ctrl_i,
  input  wire logic       sel_i,     // this cell is the next free slot
  input  wire logic       valid_i,   // this cell lies below the entry count
  input  wire entry_t     add_i,
  input  wire entry_t     next_i,    // route held by the following cell
  input  wire carry_t     carry_i,
  output entry_t          entry_o,
  output carry_t          carry_o
);

  entry_t entry_q;
  carry_t carry_q, carry_d;
  logic   match_rm, match_lk, take;

  // Compare the stored route with the key.
  assign match_rm = valid_i && (entry_q.dest == ctrl_i.key_dest);
  assign match_lk = match_rm && (entry_q.iface == ctrl_i.key_iface);
  // A strictly smaller metric wins, so the earliest route keeps a tie.
  assign take     = match_lk && (!carry_i.hit || (entry_q.cost < carry_i.cost));

  always_comb begin
    carry_d.found   = carry_i.found | match_rm;
    carry_d.hit     = carry_i.hit | match_lk;
    carry_d.cost    = take ? entry_q.cost : carry_i.cost;
    carry_d.gateway = take ? entry_q.gateway : carry_i.gateway;
  end

  // Search state advances one cell per cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      carry_q <= '0;
    end else begin
      carry_q <= carry_d;
    end
  end

  // Route storage: written by add, or shifted down behind a removed route.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_en && sel_i) begin
      entry_q <= add_i;
    end else if (ctrl_i.shift_en && carry_q.found) begin
      entry_q <= next_i;
    end
  end

  assign entry_o = entry_q;
  assign carry_o = carry_q;

endmodule

`default_nettype wire

### tb/sv/route_table_min_metric_lookup_tb.sv
// ----------------------------------------------------------------------------
// Route table lookup testbench
// Drives add, remove, lookup and clear transactions through the start/busy
// handshake with random gaps, predicts untyped results from a local copy of the
// route table and checks each strobed result against the oldest expectation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module route_table_min_metric_lookup_tb;
  import rtmml_pkg::*;

  localparam int unsigned Depth      = MaxEntriesDef;
  localparam int unsigned NumRandom  = 1300;
  localparam int unsigned QuietTail  = 200;
  localparam int unsigned StallLimit = 5000;
  localparam int unsigned NumRows    = 20;

  typedef struct packed {
    logic [CmdW-1:0]   cmd;
    logic [AddrW-1:0]  dest;
    logic [AddrW-1:0]  gw;
    logic [IfaceW-1:0] iface;
    logic              kind;
    logic [CostW-1:0]  metric;
  } route_cmd_t;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [AddrW-1:0]   gw;
    logic [CountW-1:0]  count;
  } route_resp_t;

  typedef struct packed {
    route_cmd_t  op;
    logic        typed;
    route_resp_t resp;
  } dir_row_t;

  // Directed rows: typed responses only where they are obvious.
  localparam dir_row_t DirRows [0:NumRows-1] = '{
    '{'{CmdLookup, 32'h0, 32'h0, 4'h0, 1'b0, 30'h0}, 1'b1, '{StMissing, 32'h0, 8'd0}},
    '{'{CmdRemove, 32'h0, 32'h0, 4'h0, 1'b0, 30'h0}, 1'b1, '{StMissing, 32'h0, 8'd0}},
    '{'{CmdAdd, 32'h0, 32'h0, 4'h0, 1'b0, 30'h0}, 1'b1, '{StOk, 32'h0, 8'd1}},
    '{'{CmdAdd, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'hF, 1'b1, 30'h3FFF_FFFF}, 1'b1,
      '{StOk, 32'h0, 8'd2}},
    '{'{CmdLookup, 32'hFFFF_FFFF, 32'h0, 4'hF, 1'b0, 30'h0}, 1'b1,
      '{StOk, 32'hFFFF_FFFF, 8'd2}},
    '{'{CmdLookup, 32'h0, 32'h0, 4'h0, 1'b0, 30'h0}, 1'b1, '{StOk, 32'h0, 8'd2}},
    '{'{CmdLookup, 32'h0, 32'h0, 4'h1, 1'b0, 30'h0}, 1'b1, '{StMissing, 32'h0, 8'd2}},
    '{'{CmdAdd, 32'h10, 32'hA, 4'h3, 1'b0, 30'd5}, 1'b0, '0},
    '{'{CmdAdd, 32'h10, 32'hB, 4'h3, 1'b1, 30'd5}, 1'b0, '0},
    '{'{CmdAdd, 32'h10, 32'hC, 4'h3, 1'b0, 30'd2}, 1'b0, '0},
    '{'{CmdAdd, 32'h10, 32'hD, 4'h4, 1'b1, 30'd1}, 1'b0, '0},
    '{'{CmdLookup, 32'h10, 32'h0, 4'h3, 1'b0, 30'h0}, 1'b0, '0},
    '{'{CmdRemove, 32'h10, 32'h0, 4'h0, 1'b0, 30'h0}, 1'b0, '0},
    '{'{CmdLookup, 32'h10, 32'h0, 4'h3, 1'b0, 30'h0}, 1'b0, '0},
    '{'{CmdRemove, 32'h99, 32'h0, 4'h0, 1'b0, 30'h0}, 1'b0, '0},
    '{'{CmdClear, 32'h0, 32'h0, 4'h0, 1'b0, 30'h0}, 1'b1, '{StOk, 32'h0, 8'd0}},
    '{'{CmdLookup, 32'h10, 32'h0, 4'h3, 1'b0, 30'h0}, 1'b1, '{StMissing, 32'h0, 8'd0}},
    '{'{CmdAdd, 32'h5, 32'h1, 4'h2, 1'b0, 30'd7}, 1'b0, '0},
    '{'{CmdAdd, 32'h5, 32'h2, 4'h2, 1'b1, 30'd7}, 1'b0, '0},
    '{'{CmdLookup, 32'h5, 32'h0, 4'h2, 1'b0, 30'h0}, 1'b0, '0}
  };

  logic               clk_i;
  logic               rst_ni;
  logic               start;
  logic               busy;
  logic [CmdW-1:0]    cmd_i;
  logic [AddrW-1:0]   dest_addr_i;
  logic [AddrW-1:0]   gateway_addr_i;
  logic [IfaceW-1:0]  iface_id_i;
  logic               route_kind_i;
  logic [CostW-1:0]   route_metric_i;
  logic               result_valid_o;
  logic [StatusW-1:0] status_o;
  logic [AddrW-1:0]   found_gateway_o;
  logic [CountW-1:0]  entry_count_o;

  // Shadow route table.
  logic [AddrW-1:0]  tbl_dest [Depth];
  logic [AddrW-1:0]  tbl_gw [Depth];
  logic [IfaceW-1:0] tbl_iface [Depth];
  logic              tbl_kind [Depth];
  logic [CostW-1:0]  tbl_cost [Depth];
  int unsigned       tbl_count;

  route_resp_t pending_resp_q[$];
  logic        cur_typed;
  route_resp_t cur_resp;
  int unsigned mismatches;
  int unsigned idle_cycles;
  logic [AddrW-1:0]  dest_pool [6];
  logic [IfaceW-1:0] iface_pool [2];

  route_table_min_metric_lookup dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .cmd_i          (cmd_i),
    .dest_addr_i    (dest_addr_i),
    .gateway_addr_i (gateway_addr_i),
    .iface_id_i     (iface_id_i),
    .route_kind_i   (route_kind_i),
    .route_metric_i (route_metric_i),
    .result_valid_o (result_valid_o),
    .status_o       (status_o),
    .found_gateway_o(found_gateway_o),
    .entry_count_o  (entry_count_o)
  );

  // Clock generation.
  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  // Applies one command to the shadow table and returns the route response.
  function automatic route_resp_t apply_route_cmd(route_cmd_t op);
    route_resp_t resp;
    logic [CostW:0] best;
    int          pos;
    logic        hit;
    resp = '{StOk, '0, '0};
    hit  = 1'b0;
    best = 31'h4000_0000;
    pos  = -1;
    case (op.cmd)
      CmdAdd: begin
        if (tbl_count >= Depth) begin
          resp.status = StFull;
        end else begin
          tbl_dest[tbl_count]  = op.dest;
          tbl_gw[tbl_count]    = op.gw;
          tbl_iface[tbl_count] = op.iface;
          tbl_kind[tbl_count]  = op.kind;
          tbl_cost[tbl_count]  = op.metric;
          tbl_count++;
        end
      end
      CmdRemove: begin
        for (int i = 0; i < tbl_count; i++) begin
          if (pos < 0 && tbl_dest[i] == op.dest) pos = i;
        end
        if (pos < 0) begin
          resp.status = StMissing;
        end else begin
          for (int i = pos; i + 1 < tbl_count; i++) begin
            tbl_dest[i]  = tbl_dest[i+1];
            tbl_gw[i]    = tbl_gw[i+1];
            tbl_iface[i] = tbl_iface[i+1];
            tbl_kind[i]  = tbl_kind[i+1];
            tbl_cost[i]  = tbl_cost[i+1];
          end
          tbl_count--;
        end
      end
      CmdLookup: begin
        // A strictly smaller metric wins, so the earliest route keeps a tie.
        for (int i = 0; i < tbl_count; i++) begin
          if (tbl_dest[i] == op.dest && tbl_iface[i] == op.iface &&
              {1'b0, tbl_cost[i]} < best) begin
            best    = {1'b0, tbl_cost[i]};
            resp.gw = tbl_gw[i];
            hit     = 1'b1;
          end
        end
        if (!hit) begin
          resp.status = StMissing;
          resp.gw     = '0;
        end
      end
      default: tbl_count = 0;
    endcase
    resp.count = tbl_count[CountW-1:0];
    return resp;
  endfunction

  // Result checking, prediction on acceptance, and the stall watchdog.
  always @(posedge clk_i) begin
    route_resp_t want;
    route_resp_t pred;
    logic        progress;
    progress = 1'b0;
    if (rst_ni) begin
      if (result_valid_o) begin
        progress = 1'b1;
        if (pending_resp_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Unexpected result: status %0d gw %h count %0d",
                     status_o, found_gateway_o, entry_count_o);
        end else begin
          want = pending_resp_q.pop_front();
          if (want.status !== status_o || want.gw !== found_gateway_o ||
              want.count !== entry_count_o) begin
            mismatches++;
            if (mismatches <= 10)
              $display("Mismatch: expected status %0d gw %h count %0d, got %0d %h %0d",
                       want.status, want.gw, want.count,
                       status_o, found_gateway_o, entry_count_o);
          end
        end
      end
      if (start && !busy) begin
        progress = 1'b1;
        pred = apply_route_cmd('{cmd_i, dest_addr_i, gateway_addr_i, iface_id_i,
                                 route_kind_i, route_metric_i});
        pending_resp_q.push_back(cur_typed ? cur_resp : pred);
      end
      idle_cycles = progress ? 0 : idle_cycles + 1;
      if (idle_cycles >= StallLimit) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // Presents one transaction and holds it until the handshake completes.
  task automatic send_route_cmd(route_cmd_t op, logic typed, route_resp_t resp);
    @(negedge clk_i);
    start          = 1'b1;
    cmd_i          = op.cmd;
    dest_addr_i    = op.dest;
    gateway_addr_i = op.gw;
    iface_id_i     = op.iface;
    route_kind_i   = op.kind;
    route_metric_i = op.metric;
    cur_typed      = typed;
    cur_resp       = resp;
    do @(posedge clk_i); while (busy);
  endtask

  // Random command with destinations and interfaces drawn mostly from pools.
  function automatic route_cmd_t random_route_cmd(logic [CmdW-1:0] cmd);
    route_cmd_t op;
    op.cmd    = cmd;
    op.dest   = ($urandom_range(0, 3) != 0) ? dest_pool[$urandom_range(0, 5)]
                                            : $urandom();
    op.gw     = $urandom();
    op.iface  = ($urandom_range(0, 1) != 0) ? iface_pool[$urandom_range(0, 1)]
                                            : IfaceW'($urandom_range(0, 15));
    op.kind   = 1'($urandom_range(0, 1));
    op.metric = ($urandom_range(0, 2) == 0) ? CostW'($urandom_range(0, 3))
                                            : CostW'($urandom_range(0, 32'h3FFF_FFFF));
    return op;
  endfunction

  // Stimulus.
  initial begin
    int unsigned sent;
    int unsigned burst;
    int unsigned roll;
    logic [CmdW-1:0] cmd;
    start          = 1'b0;
    cmd_i          = CmdAdd;
    dest_addr_i    = '0;
    gateway_addr_i = '0;
    iface_id_i     = '0;
    route_kind_i   = 1'b0;
    route_metric_i = '0;
    cur_typed      = 1'b0;
    cur_resp       = '0;
    tbl_count      = 0;
    mismatches     = 0;
    idle_cycles    = 0;
    sent           = 0;
    burst          = 0;
    rst_ni         = 1'b0;
    for (int i = 0; i < 6; i++) dest_pool[i] = $urandom();
    for (int i = 0; i < 2; i++) iface_pool[i] = IfaceW'($urandom_range(0, 15));
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (int r = 0; r < NumRows; r++) begin
      send_route_cmd(DirRows[r].op, DirRows[r].typed, DirRows[r].resp);
    end

    while (sent < NumRandom) begin
      // Occasionally fill the table past full so the full case is exercised.
      if (burst == 0 && $urandom_range(0, 19) == 0) burst = Depth - tbl_count + 3;
      if (burst != 0) begin
        cmd = CmdAdd;
        burst--;
      end else begin
        roll = $urandom_range(0, 99);
        cmd  = (roll < 35) ? CmdAdd : (roll < 60) ? CmdRemove :
               (roll < 96) ? CmdLookup : CmdClear;
      end
      // Random gaps, none near the end.
      if (sent < NumRandom - QuietTail && burst == 0 && $urandom_range(0, 3) == 0) begin
        @(negedge clk_i);
        start = 1'b0;
        repeat ($urandom_range(1, 14) - 1) @(negedge clk_i);
      end
      // Hold off until the block has drained every outstanding transaction.
      if (sent % 300 == 150) begin
        @(negedge clk_i);
        start = 1'b0;
        while (pending_resp_q.size() != 0) @(negedge clk_i);
      end
      send_route_cmd(random_route_cmd(cmd), 1'b0, '0);
      sent++;
    end
    @(negedge clk_i);
    start = 1'b0;

    while (pending_resp_q.size() != 0) @(negedge clk_i);
    repeat (Depth + 10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
